>>> rtl/core/tlg_pkg.sv
package tlg_pkg;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_DLOAD = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    // work phases of one tetrahedron
    typedef logic [1:0] phase_t;
    localparam phase_t PH_CROSS = 2'd0;
    localparam phase_t PH_VOL   = 2'd1;
    localparam phase_t PH_NUM   = 2'd2;

    // corner codes
    localparam logic [1:0] CORNER_I = 2'd3;

    // cyclic successor of an axis
    function automatic logic [1:0] axis_succ(input logic [1:0] c);
        logic [1:0] r;
        case (c)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // axis of the left operand for cross product term t of component c
    function automatic logic [1:0] axis_left(input logic [1:0] c, input logic t);
        return t ? axis_succ(axis_succ(c)) : axis_succ(c);
    endfunction

    // axis of the right operand for cross product term t of component c
    function automatic logic [1:0] axis_right(input logic [1:0] c, input logic t);
        return t ? axis_succ(c) : axis_succ(axis_succ(c));
    endfunction

endpackage

>>> rtl/core/tetrahedron_linear_gradient_top.sv
// Gradient of the linear interpolant on a tetrahedron. Corners arrive one per
// transfer in the order j, k, h, i (corner codes 0..3); corners j, k and h are
// stored and stay for later use. Corner i starts the work and the input stalls
// until its result is in the output register. Products and sums are exact and
// run through one shared serial multiply-accumulate unit (one wide add per
// cycle); each of the three gradient components ends in a division by the volume
// in one restoring divider, rounded to nearest and saturated. There are 30
// products in all. A zero volume ends after the 21st product with a zero
// gradient and degenerate set.
module tetrahedron_linear_gradient_top #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   corner,
    input  logic signed [WORD_WIDTH-1:0] pos_x,
    input  logic signed [WORD_WIDTH-1:0] pos_y,
    input  logic signed [WORD_WIDTH-1:0] pos_z,
    input  logic signed [WORD_WIDTH-1:0] node_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [WORD_WIDTH-1:0] grad_x,
    output logic signed [WORD_WIDTH-1:0] grad_y,
    output logic signed [WORD_WIDTH-1:0] grad_z,
    output logic                         degenerate
);

    localparam int W    = WORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int CW   = 2 * DW + 1;
    localparam int AW   = CW + DW + 1;
    localparam int QW   = AW + FRAC_BITS + 2;
    localparam int CNTW = $clog2(DW);
    localparam int QCW  = $clog2(QW);

    tlg_pkg::state_t state_reg, state_next;

    // corner storage, slot 3 holds corner i
    logic signed [W-1:0]  pos_reg [0:3][0:2];
    logic signed [W-1:0]  val_reg [0:3];

    // cross products, face by axis
    logic signed [CW-1:0] cr_reg  [0:2][0:2];

    // sequencing counters
    tlg_pkg::phase_t      ph_reg;
    logic [1:0]           f_reg, c_reg, t_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic [QCW-1:0]       dcnt_reg;

    // multiply-accumulate unit
    logic signed [AW-1:0] acc_reg, mcand_reg, acc_step;
    logic [DW-1:0]        mplier_reg;
    logic                 sub_reg;

    // divider
    logic [AW-1:0]        ad_reg;
    logic                 dneg_reg, neg_reg;
    logic [AW:0]          rem_reg;
    logic [QW-1:0]        dq_reg;

    logic signed [W-1:0]  res_reg [0:2];
    logic                 degen_reg;

    logic signed [W-1:0]  grad_x_reg, grad_y_reg, grad_z_reg;
    logic                 degenerate_reg, out_valid_reg;

    logic in_xfer, out_free, mul_last, div_last;

    assign in_stall  = (state_reg != tlg_pkg::S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign mul_last  = (cnt_reg == CNTW'(DW - 1));
    assign div_last  = (dcnt_reg == QCW'(QW - 1));

    assign out_valid  = out_valid_reg;
    assign grad_x     = grad_x_reg;
    assign grad_y     = grad_y_reg;
    assign grad_z     = grad_z_reg;
    assign degenerate = degenerate_reg;

    // edge vectors of the three faces and of h minus i
    logic signed [DW-1:0] fa [0:2][0:2];
    logic signed [DW-1:0] fb [0:2][0:2];
    logic signed [DW-1:0] hi [0:2];
    logic signed [DW-1:0] fd [0:2];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            fa[0][a] = DW'(pos_reg[3][a]) - DW'(pos_reg[1][a]);
            fb[0][a] = DW'(pos_reg[2][a]) - DW'(pos_reg[1][a]);
            fa[1][a] = DW'(pos_reg[3][a]) - DW'(pos_reg[2][a]);
            fb[1][a] = DW'(pos_reg[0][a]) - DW'(pos_reg[2][a]);
            fa[2][a] = DW'(pos_reg[1][a]) - DW'(pos_reg[3][a]);
            fb[2][a] = DW'(pos_reg[0][a]) - DW'(pos_reg[3][a]);
            hi[a]    = DW'(pos_reg[2][a]) - DW'(pos_reg[3][a]);
            fd[a]    = DW'(val_reg[a]) - DW'(val_reg[3]);
        end
    end

    // operand selection for the next product
    logic [1:0]           ax_l, ax_r, ri, ai;
    logic signed [AW-1:0] mcand_sel;
    logic [DW-1:0]        mplier_sel;

    always_comb
    begin
        ax_l = tlg_pkg::axis_left(c_reg, t_reg[0]);
        ax_r = tlg_pkg::axis_right(c_reg, t_reg[0]);
        ri   = (ph_reg == tlg_pkg::PH_VOL) ? 2'd2 : t_reg;
        ai   = (ph_reg == tlg_pkg::PH_VOL) ? t_reg : c_reg;
        if (ph_reg == tlg_pkg::PH_CROSS)
        begin
            mcand_sel  = AW'(fa[f_reg][ax_l]);
            mplier_sel = fb[f_reg][ax_r];
        end
        else
        begin
            mcand_sel  = AW'(cr_reg[ri][ai]);
            mplier_sel = (ph_reg == tlg_pkg::PH_VOL) ? hi[t_reg] : fd[t_reg];
        end
    end

    // one signed shift-add step, top multiplier bit carries negative weight
    logic                 negate;
    logic [AW-1:0]        addend;
    always_comb
    begin
        negate   = sub_reg ^ mul_last;
        addend   = mplier_reg[0] ? (mcand_reg ^ {AW{negate}}) : '0;
        acc_step = acc_reg + $signed(addend) + AW'(mplier_reg[0] & negate);
    end

    // one restoring division step and final saturation
    logic [AW+1:0]        rem_sh, rem_diff;
    logic                 ge;
    logic [QW-1:0]        q_step, lim;
    logic [W-1:0]         mag, sat_val;
    logic [AW-1:0]        acc_abs;
    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[QW-1]};
        rem_diff = rem_sh - {1'b0, ad_reg, 1'b0};
        ge       = (rem_sh >= {1'b0, ad_reg, 1'b0});
        q_step   = {dq_reg[QW-2:0], ge};
        lim      = (QW'(1) << (W - 1)) - QW'(!neg_reg);
        mag      = (q_step > lim) ? lim[W-1:0] : q_step[W-1:0];
        sat_val  = neg_reg ? (~mag + W'(1)) : mag;
        acc_abs  = acc_reg[AW-1] ? (~acc_reg + AW'(1)) : acc_reg;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlg_pkg::S_IDLE:
                if (in_xfer && corner == tlg_pkg::CORNER_I)
                    state_next = tlg_pkg::S_LOAD;
            tlg_pkg::S_LOAD:
                state_next = tlg_pkg::S_MUL;
            tlg_pkg::S_MUL:
                if (mul_last)
                begin
                    if (ph_reg == tlg_pkg::PH_VOL && t_reg == 2'd2)
                        state_next = tlg_pkg::S_CHECK;
                    else if (ph_reg == tlg_pkg::PH_NUM && t_reg == 2'd2)
                        state_next = tlg_pkg::S_DLOAD;
                    else
                        state_next = tlg_pkg::S_LOAD;
                end
            tlg_pkg::S_CHECK:
                state_next = (acc_reg == '0) ? tlg_pkg::S_DONE : tlg_pkg::S_LOAD;
            tlg_pkg::S_DLOAD:
                state_next = tlg_pkg::S_DIV;
            tlg_pkg::S_DIV:
                if (div_last)
                    state_next = (c_reg == 2'd2) ? tlg_pkg::S_DONE : tlg_pkg::S_LOAD;
            tlg_pkg::S_DONE:
                if (out_free)
                    state_next = tlg_pkg::S_IDLE;
            default:
                state_next = tlg_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlg_pkg::S_IDLE;
            ph_reg        <= tlg_pkg::PH_CROSS;
            f_reg         <= '0;
            c_reg         <= '0;
            t_reg         <= '0;
            cnt_reg       <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tlg_pkg::S_IDLE)
            begin
                ph_reg <= tlg_pkg::PH_CROSS;
                f_reg  <= '0;
                c_reg  <= '0;
                t_reg  <= '0;
            end
            if (state_reg == tlg_pkg::S_LOAD)
                cnt_reg <= '0;
            // advance through products
            if (state_reg == tlg_pkg::S_MUL)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
                if (mul_last)
                begin
                    if (ph_reg == tlg_pkg::PH_CROSS)
                    begin
                        if (t_reg == 2'd0)
                            t_reg <= 2'd1;
                        else
                        begin
                            t_reg <= '0;
                            if (c_reg == 2'd2)
                            begin
                                c_reg <= '0;
                                if (f_reg == 2'd2)
                                    ph_reg <= tlg_pkg::PH_VOL;
                                else
                                    f_reg <= f_reg + 2'd1;
                            end
                            else
                                c_reg <= c_reg + 2'd1;
                        end
                    end
                    else if (t_reg != 2'd2)
                        t_reg <= t_reg + 2'd1;
                end
            end
            if (state_reg == tlg_pkg::S_CHECK)
            begin
                ph_reg <= tlg_pkg::PH_NUM;
                c_reg  <= '0;
                t_reg  <= '0;
            end
            if (state_reg == tlg_pkg::S_DLOAD)
                dcnt_reg <= '0;
            if (state_reg == tlg_pkg::S_DIV)
            begin
                dcnt_reg <= dcnt_reg + QCW'(1);
                if (div_last)
                begin
                    c_reg <= c_reg + 2'd1;
                    t_reg <= '0;
                end
            end
            // output register handshake
            if (state_reg == tlg_pkg::S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        // corner store
        if (in_xfer)
        begin
            pos_reg[corner][0] <= pos_x;
            pos_reg[corner][1] <= pos_y;
            pos_reg[corner][2] <= pos_z;
            val_reg[corner]    <= node_value;
        end
        // operand load, first term of each sum clears the accumulator
        if (state_reg == tlg_pkg::S_LOAD)
        begin
            mcand_reg  <= mcand_sel;
            mplier_reg <= mplier_sel;
            sub_reg    <= (ph_reg == tlg_pkg::PH_CROSS) && t_reg[0];
            if (t_reg == 2'd0)
                acc_reg <= '0;
        end
        // serial multiply step
        if (state_reg == tlg_pkg::S_MUL)
        begin
            acc_reg    <= acc_step;
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
            if (mul_last && ph_reg == tlg_pkg::PH_CROSS && t_reg == 2'd1)
                cr_reg[f_reg][c_reg] <= acc_step[CW-1:0];
        end
        // volume check
        if (state_reg == tlg_pkg::S_CHECK)
        begin
            ad_reg    <= acc_abs;
            dneg_reg  <= acc_reg[AW-1];
            degen_reg <= (acc_reg == '0);
            if (acc_reg == '0)
            begin
                res_reg[0] <= '0;
                res_reg[1] <= '0;
                res_reg[2] <= '0;
            end
        end
        // divider load: rounded quotient via (2|n|<<F + |d|) / 2|d|
        if (state_reg == tlg_pkg::S_DLOAD)
        begin
            neg_reg <= acc_reg[AW-1] ^ dneg_reg;
            rem_reg <= '0;
            dq_reg  <= QW'({acc_abs, {(FRAC_BITS + 1){1'b0}}}) + QW'(ad_reg);
        end
        // divider step
        if (state_reg == tlg_pkg::S_DIV)
        begin
            rem_reg <= ge ? rem_diff[AW:0] : rem_sh[AW:0];
            dq_reg  <= q_step;
            if (div_last)
                res_reg[c_reg] <= sat_val;
        end
        // result transfer into the output register
        if (state_reg == tlg_pkg::S_DONE && out_free)
        begin
            grad_x_reg     <= res_reg[0];
            grad_y_reg     <= res_reg[1];
            grad_z_reg     <= res_reg[2];
            degenerate_reg <= degen_reg;
        end
    end

endmodule

>>> rtl/core/tlg_check.sv
module tlg_check #(
    parameter int WORD_WIDTH = 32
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic [1:0]            corner,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [WORD_WIDTH-1:0] grad_x,
    input logic [WORD_WIDTH-1:0] grad_y,
    input logic [WORD_WIDTH-1:0] grad_z,
    input logic                  degenerate
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(grad_x) && $stable(grad_y)
            && $stable(grad_z) && $stable(degenerate))
        else $error("stalled result changed");

    // degenerate volume gives a zero gradient
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> grad_x == '0 && grad_y == '0 && grad_z == '0)
        else $error("degenerate result with nonzero gradient");

    // stored corners keep the input open
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && corner != tlg_pkg::CORNER_I |=> !in_stall)
        else $error("stall after a stored corner");

    // corner i starts the computation
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && corner == tlg_pkg::CORNER_I |=> in_stall)
        else $error("no stall after corner i");

endmodule

bind tetrahedron_linear_gradient_top tlg_check #(.WORD_WIDTH(WORD_WIDTH)) u_tlg_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .corner     (corner),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .grad_x     (grad_x),
    .grad_y     (grad_y),
    .grad_z     (grad_z),
    .degenerate (degenerate)
);

>>> bench/tlg_gradient_checker.sv
`timescale 1ns / 100ps

module tlg_gradient_checker #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [1:0]                   corner,
    input  logic signed [WORD_WIDTH-1:0] pos_x,
    input  logic signed [WORD_WIDTH-1:0] pos_y,
    input  logic signed [WORD_WIDTH-1:0] pos_z,
    input  logic signed [WORD_WIDTH-1:0] node_value,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic signed [WORD_WIDTH-1:0] grad_x,
    input  logic signed [WORD_WIDTH-1:0] grad_y,
    input  logic signed [WORD_WIDTH-1:0] grad_z,
    input  logic                         degenerate,
    output int                           errors,
    output int                           pending
);

    typedef logic signed [255:0] wide_t;
    typedef wide_t vec3_t [3];
    typedef logic signed [WORD_WIDTH-1:0] word_t;

    typedef struct {
        word_t gx;
        word_t gy;
        word_t gz;
        logic  degen;
    } gradient_t;

    // stored corners j, k, h
    word_t     stored_pos [3][3];
    word_t     stored_val [3];
    gradient_t grad_queue [$];

    assign pending = grad_queue.size();

    function automatic vec3_t vdiff(input word_t a [3], input word_t b [3]);
        vec3_t r;
        for (int c = 0; c < 3; c++)
            r[c] = wide_t'(a[c]) - wide_t'(b[c]);
        return r;
    endfunction

    function automatic vec3_t vcross(input vec3_t a, input vec3_t b);
        vec3_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    // round to nearest, ties away from zero, then saturate
    function automatic word_t scaled_quotient(input wide_t num, input wide_t den);
        wide_t an;
        wide_t ad;
        wide_t q;
        wide_t lim;
        logic  neg;
        word_t m;
        neg = num[255] != den[255];
        an  = num[255] ? -num : num;
        ad  = den[255] ? -den : den;
        q   = ((an <<< (FRAC_BITS + 1)) + ad) / (ad <<< 1);
        lim = (wide_t'(1) <<< (WORD_WIDTH - 1)) - (neg ? 0 : 1);
        if (q > lim)
            q = lim;
        m = q[WORD_WIDTH-1:0];
        return neg ? -m : m;
    endfunction

    function automatic gradient_t predict_gradient(input word_t pi [3], input word_t vi);
        vec3_t     nj;
        vec3_t     nk;
        vec3_t     nh;
        vec3_t     grad_num;
        wide_t     vol;
        wide_t     fj;
        wide_t     fk;
        wide_t     fh;
        gradient_t g;
        nj  = vcross(vdiff(pi, stored_pos[1]), vdiff(stored_pos[2], stored_pos[1]));
        nk  = vcross(vdiff(pi, stored_pos[2]), vdiff(stored_pos[0], stored_pos[2]));
        nh  = vcross(vdiff(stored_pos[1], pi), vdiff(stored_pos[0], pi));
        begin
            vec3_t a;
            a   = vdiff(stored_pos[2], pi);
            vol = a[0] * nh[0] + a[1] * nh[1] + a[2] * nh[2];
        end
        if (vol == 0)
        begin
            g = '{gx: '0, gy: '0, gz: '0, degen: 1'b1};
            return g;
        end
        fj = wide_t'(stored_val[0]) - wide_t'(vi);
        fk = wide_t'(stored_val[1]) - wide_t'(vi);
        fh = wide_t'(stored_val[2]) - wide_t'(vi);
        for (int c = 0; c < 3; c++)
            grad_num[c] = nj[c] * fj + nk[c] * fk + nh[c] * fh;
        g.gx    = scaled_quotient(grad_num[0], vol);
        g.gy    = scaled_quotient(grad_num[1], vol);
        g.gz    = scaled_quotient(grad_num[2], vol);
        g.degen = 1'b0;
        return g;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial errors = 0;

    // input transfers: store corners or predict a gradient
    always @(posedge clk)
    begin
        word_t pi [3];
        if (rst_n && in_valid && !in_stall)
        begin
            pi = '{pos_x, pos_y, pos_z};
            if (corner == tlg_pkg::CORNER_I)
                grad_queue.push_back(predict_gradient(pi, node_value));
            else
            begin
                stored_pos[corner] = pi;
                stored_val[corner] = node_value;
            end
        end
    end

    // output transfers: compare with the oldest prediction
    always @(posedge clk)
    begin
        gradient_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (grad_queue.size() == 0)
            begin
                $display("%0t: gradient transfer with none expected", $realtime);
                errors++;
            end
            else
            begin
                want = grad_queue.pop_front();
                if (grad_x !== want.gx)
                    report_mismatch("grad_x", grad_x, want.gx);
                if (grad_y !== want.gy)
                    report_mismatch("grad_y", grad_y, want.gy);
                if (grad_z !== want.gz)
                    report_mismatch("grad_z", grad_z, want.gz);
                if (degenerate !== want.degen)
                    report_mismatch("degenerate", degenerate, want.degen);
            end
        end
    end

endmodule

>>> bench/tb_tetrahedron_linear_gradient_top.sv
`timescale 1ns / 100ps

module tb_tetrahedron_linear_gradient_top;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_WIDTH = 32;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_TETS = 118;

    localparam logic [1:0] CORNER_J = 2'd0;
    localparam logic [1:0] CORNER_K = 2'd1;
    localparam logic [1:0] CORNER_H = 2'd2;

    localparam logic [31:0] WORD_MAX = 32'h7fffffff;
    localparam logic [31:0] WORD_MIN = 32'h80000000;
    localparam logic [31:0] ONE      = 32'h00010000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  corner;
    logic signed [WORD_WIDTH-1:0] pos_x;
    logic signed [WORD_WIDTH-1:0] pos_y;
    logic signed [WORD_WIDTH-1:0] pos_z;
    logic signed [WORD_WIDTH-1:0] node_value;
    logic        out_valid;
    logic        out_stall;
    logic signed [WORD_WIDTH-1:0] grad_x;
    logic signed [WORD_WIDTH-1:0] grad_y;
    logic signed [WORD_WIDTH-1:0] grad_z;
    logic        degenerate;
    int          errors;
    int          pending;
    int          idle_cycles;
    logic        no_gaps;

    tetrahedron_linear_gradient_top #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .corner     (corner),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .node_value (node_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .grad_x     (grad_x),
        .grad_y     (grad_y),
        .grad_z     (grad_z),
        .degenerate (degenerate)
    );

    tlg_gradient_checker #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .corner     (corner),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .node_value (node_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .grad_x     (grad_x),
        .grad_y     (grad_y),
        .grad_z     (grad_z),
        .degenerate (degenerate),
        .errors     (errors),
        .pending    (pending)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        if (no_gaps)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(20, 90);
        return $urandom_range(0, 2);
    endfunction

    // mix of full-range words, modest Q16.16 values and extremes
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return WORD_MAX;
            3:       return WORD_MIN;
            4:       return 32'd0;
            default: return $urandom_range(0, 32'h001fffff) - 32'h00100000;
        endcase
    endfunction

    // one input transfer, entered and left at a falling edge
    task automatic send_corner(input logic [1:0] c, input logic [31:0] x,
                               input logic [31:0] y, input logic [31:0] z,
                               input logic [31:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        corner     <= c;
        pos_x      <= x;
        pos_y      <= y;
        pos_z      <= z;
        node_value <= v;
        #1;
        while (in_stall)
        begin
            @(negedge clk);
            #1;
        end
        @(negedge clk);
    endtask

    task automatic send_random_tet();
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        for (int n = 0; n < 3; n++)
            send_corner(n[1:0], rand_word(), rand_word(), rand_word(), rand_word());
        x = rand_word();
        y = rand_word();
        z = rand_word();
        // now and then put corner i on corner j's plane
        if ($urandom_range(0, 9) == 0)
            z = i_checker.stored_pos[0][2];
        send_corner(tlg_pkg::CORNER_I, x, y, z, rand_word());
    endtask

    // receiver stall
    always @(negedge clk)
    begin
        if (!rst_n || no_gaps)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 40) == 0)
            out_stall <= 1'b1;
        else if (out_stall)
            out_stall <= ($urandom_range(0, 15) != 0);
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        corner      = CORNER_J;
        pos_x       = '0;
        pos_y       = '0;
        pos_z       = '0;
        node_value  = '0;
        out_stall   = 1'b0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // unit tetrahedron, linear field with gradient (1, 2, 3)
        send_corner(CORNER_J, ONE, 0, 0, ONE);
        send_corner(CORNER_K, 0, ONE, 0, 2 * ONE);
        send_corner(CORNER_H, 0, 0, ONE, 3 * ONE);
        send_corner(tlg_pkg::CORNER_I, 0, 0, 0, 0);
        // reuse stored corners, other value at i
        send_corner(tlg_pkg::CORNER_I, 0, 0, 0, WORD_MAX);
        // opposite orientation
        send_corner(tlg_pkg::CORNER_I, ONE, ONE, ONE, ONE);
        // zero volume: i in the plane of j, k, h
        send_corner(tlg_pkg::CORNER_I, ONE / 2, ONE / 2, 0, ONE);
        // zero volume: i on top of j
        send_corner(tlg_pkg::CORNER_I, ONE, 0, 0, WORD_MIN);
        // tiny volume with huge value steps: saturation to the positive limit
        send_corner(CORNER_J, 1, 0, 0, WORD_MAX);
        send_corner(CORNER_K, 0, 1, 0, WORD_MIN);
        send_corner(CORNER_H, 0, 0, 1, WORD_MAX);
        send_corner(tlg_pkg::CORNER_I, 0, 0, 0, WORD_MIN);
        // extreme coordinates
        send_corner(CORNER_J, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
        send_corner(CORNER_K, WORD_MIN, WORD_MAX, 0, WORD_MAX);
        send_corner(CORNER_H, 0, WORD_MIN, WORD_MIN, 0);
        send_corner(tlg_pkg::CORNER_I, WORD_MIN, 0, WORD_MAX, WORD_MAX);
        send_corner(tlg_pkg::CORNER_I, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN);
        // constant field gives zero gradient
        send_corner(CORNER_J, ONE, 0, 0, 5 * ONE);
        send_corner(CORNER_K, 0, ONE, 0, 5 * ONE);
        send_corner(CORNER_H, 0, 0, ONE, 5 * ONE);
        send_corner(tlg_pkg::CORNER_I, 0, 0, 0, 5 * ONE);

        // random tetrahedra, with stretches of no idling and some loose corners
        for (int t = 0; t < RANDOM_TETS; t++)
        begin
            if (t % 20 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 7) == 0)
                send_corner(2'($urandom_range(0, 3)), rand_word(), rand_word(), rand_word(),
                            rand_word());
            else
                send_random_tet();
        end
        in_valid <= 1'b0;
        no_gaps  = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
